// ===== sv/ultrasonic_ranger_deadband_defines.svh =====
`ifndef ULTRASONIC_RANGER_DEADBAND_DEFINES_SVH
`define ULTRASONIC_RANGER_DEADBAND_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define URD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define URD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/urd_pkg.sv =====
package urd_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int DIST_BITS_DEF  = 14;

  localparam int DEADBAND_BITS  = 8;
  localparam int STOP_BITS      = 14;
  localparam int TIMEOUT_BITS   = 20;
  localparam int SCALE_BITS     = 16;
  localparam int TRIG_BITS      = 8;
  localparam int TICK_BITS      = 8;

  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [DEADBAND_BITS-1:0] DEADBAND_RST = 8'd2;
  localparam logic [STOP_BITS-1:0]     STOP_RST     = 14'd10;
  localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RST  = 20'd500000;
  localparam logic [SCALE_BITS-1:0]    SCALE_RST    = 16'd1124;
  localparam logic [TRIG_BITS-1:0]     TRIG_RST     = 8'd10;

  localparam logic [TICK_BITS-1:0]     LOW_TICKS    = 8'd2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEADBAND = 3'd0,
    REG_STOP     = 3'd1,
    REG_TIMEOUT  = 3'd2,
    REG_SCALE    = 3'd3,
    REG_TRIG     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_LOW   = 2'd0,
    PH_HIGH  = 2'd1,
    PH_WAIT  = 2'd2,
    PH_COUNT = 2'd3
  } phase_t;

endpackage

// ===== sv/ultrasonic_ranger_deadband.sv =====
// Ultrasonic ranger with deadband filter. Each input beat is one microsecond
// tick carrying the sampled echo level; each accepted beat yields exactly one
// output beat with the trigger drive for that tick, a done flag and reading on
// the tick a measurement ends, the filtered steady distance and the stop
// request. The ranging cycle is trigger low for 2 ticks, trigger high for
// trigger_width_us ticks (0 acts as 1), wait for echo high, then count echo
// width; both waits end on timeout_us ticks from cycle start. Reading is
// floor(width * scale_q16 / 65536), saturated to the distance width. The output
// beat is registered in the cycle after its input beat is accepted, and a new
// beat is taken every cycle: the sequencer update, the width-by-scale multiply
// and the deadband compare all sit between the state registers and the output
// register, and in_ready stays high whenever the output register is empty or
// being drained. Configuration writes take effect on the next clock edge.
module ultrasonic_ranger_deadband #(
  parameter int COUNT_BITS = urd_pkg::COUNT_BITS_DEF,
  parameter int DIST_BITS  = urd_pkg::DIST_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [urd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [urd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                echo_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                trigger_level,
  output logic                                measure_done,
  output logic [DIST_BITS-1:0]                reading_cm,
  output logic [DIST_BITS-1:0]                steady_cm,
  output logic                                stop_request
);
  import urd_pkg::*;

  `include "ultrasonic_ranger_deadband_defines.svh"

  localparam int CMP_BITS  = (COUNT_BITS > TIMEOUT_BITS) ? COUNT_BITS : TIMEOUT_BITS;
  localparam int PROD_BITS = COUNT_BITS + SCALE_BITS;
  localparam int SUM_BITS  = DIST_BITS + 1;
  localparam int STOP_CMP  = (DIST_BITS > STOP_BITS) ? DIST_BITS : STOP_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] DIST_MAX_C =
    COUNT_BITS'({DIST_BITS{1'b1}});

  logic [DEADBAND_BITS-1:0] deadband_cm;
  logic [STOP_BITS-1:0]     stop_below_cm;
  logic [TIMEOUT_BITS-1:0]  timeout_us;
  logic [SCALE_BITS-1:0]    scale_q16;
  logic [TRIG_BITS-1:0]     trigger_width_us;

  phase_t                   phase, phase_next;
  logic [COUNT_BITS-1:0]    cycle_ticks, cycle_ticks_next;
  logic [TICK_BITS-1:0]     phase_ticks, phase_ticks_next;
  logic [COUNT_BITS-1:0]    echo_width, echo_width_next;
  logic [DIST_BITS-1:0]     steady, steady_next;

  logic                     in_acc;
  logic                     timed_out;
  logic [COUNT_BITS-1:0]    cycle_inc;
  logic [COUNT_BITS-1:0]    width_inc;
  logic [TICK_BITS:0]       tick_sum;
  logic [TRIG_BITS-1:0]     trig_eff;
  logic [PROD_BITS-1:0]     product;
  logic [COUNT_BITS-1:0]    prod_hi;
  logic [DIST_BITS-1:0]     reading;
  logic [SUM_BITS-1:0]      reading_ext, steady_ext, db_ext;
  logic                     replace;
  logic                     finish;
  logic                     trig_next;

  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_cm      <= DEADBAND_RST;
      stop_below_cm    <= STOP_RST;
      timeout_us       <= TIMEOUT_RST;
      scale_q16        <= SCALE_RST;
      trigger_width_us <= TRIG_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEADBAND: deadband_cm      <= cfg_data[DEADBAND_BITS-1:0];
        REG_STOP:     stop_below_cm    <= cfg_data[STOP_BITS-1:0];
        REG_TIMEOUT:  timeout_us       <= cfg_data[TIMEOUT_BITS-1:0];
        REG_SCALE:    scale_q16        <= cfg_data[SCALE_BITS-1:0];
        REG_TRIG:     trigger_width_us <= cfg_data[TRIG_BITS-1:0];
        default:      ;
      endcase
    end
  end

  assign timed_out = CMP_BITS'(cycle_ticks) >= CMP_BITS'(timeout_us);
  assign cycle_inc = (cycle_ticks == COUNT_MAX) ? COUNT_MAX : cycle_ticks + 1'b1;
  assign width_inc = (echo_width == COUNT_MAX) ? COUNT_MAX : echo_width + 1'b1;
  assign tick_sum  = {1'b0, phase_ticks} + 1'b1;
  assign trig_eff  = (trigger_width_us == '0) ? TRIG_BITS'(1) : trigger_width_us;

  assign product = PROD_BITS'(echo_width) * PROD_BITS'(scale_q16);
  assign prod_hi = product[PROD_BITS-1:SCALE_BITS];
  assign reading = (prod_hi > DIST_MAX_C) ? {DIST_BITS{1'b1}} : prod_hi[DIST_BITS-1:0];

  assign reading_ext = {1'b0, reading};
  assign steady_ext  = {1'b0, steady};
  assign db_ext      = SUM_BITS'(deadband_cm);
  assign replace     = (steady_ext > reading_ext + db_ext) ||
                       (steady_ext + db_ext < reading_ext);

  always_comb begin
    phase_next       = phase;
    cycle_ticks_next = cycle_ticks;
    phase_ticks_next = phase_ticks;
    echo_width_next  = echo_width;
    steady_next      = steady;
    trig_next        = 1'b0;
    finish           = 1'b0;
    case (phase)
      PH_HIGH: begin
        trig_next        = 1'b1;
        cycle_ticks_next = cycle_inc;
        if (tick_sum >= {1'b0, trig_eff}) begin
          phase_next       = PH_WAIT;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = tick_sum[TICK_BITS-1:0];
        end
      end
      PH_WAIT: begin
        if (timed_out) begin
          finish = 1'b1;
        end else begin
          cycle_ticks_next = cycle_inc;
          if (echo_level) begin
            phase_next      = PH_COUNT;
            echo_width_next = COUNT_BITS'(1);
          end
        end
      end
      PH_COUNT: begin
        if (timed_out || !echo_level) begin
          finish = 1'b1;
        end else begin
          echo_width_next  = width_inc;
          cycle_ticks_next = cycle_inc;
        end
      end
      default: begin
        cycle_ticks_next = cycle_inc;
        if (tick_sum >= {1'b0, LOW_TICKS}) begin
          phase_next       = PH_HIGH;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = tick_sum[TICK_BITS-1:0];
        end
      end
    endcase
    if (finish) begin
      phase_next       = PH_LOW;
      cycle_ticks_next = '0;
      phase_ticks_next = '0;
      echo_width_next  = '0;
      if (replace) begin
        steady_next = reading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LOW;
      cycle_ticks <= '0;
      phase_ticks <= '0;
      echo_width  <= '0;
      steady      <= '0;
    end else if (in_acc) begin
      phase       <= phase_next;
      cycle_ticks <= cycle_ticks_next;
      phase_ticks <= phase_ticks_next;
      echo_width  <= echo_width_next;
      steady      <= steady_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      trigger_level <= trig_next;
      measure_done  <= finish;
      reading_cm    <= finish ? reading : '0;
      steady_cm     <= steady_next;
      stop_request  <= STOP_CMP'(steady_next) < STOP_CMP'(stop_below_cm);
    end
  end

  `URD_ASSERT_NEXT(a_done_restarts, in_acc && finish, phase == PH_LOW && echo_width == '0 && cycle_ticks == '0, "measurement end did not restart the cycle")
  `URD_ASSERT_NOW(a_width_idle, phase != PH_COUNT, echo_width == '0, "echo width held outside counting")
  `URD_ASSERT_NOW(a_steady_match, out_valid, steady_cm == steady, "steady output differs from kept distance")

endmodule
